@@ rtl/mf1d_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the padded 1-D median filter.
// No dependencies.
package mf1d_pkg;
    localparam int MODE_W   = 2;
    localparam int RADIUS_W = 4;
    localparam int CFG_W    = 4;
    localparam int CFG_IW   = 2;

    localparam logic [MODE_W-1:0] MODE_WRAP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [CFG_IW-1:0] REG_PADDING_MODE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_RADIUS       = 2'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BEGIN = 7'b0000010,
        S_WFIX  = 7'b0000100,
        S_FEED  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;
endpackage

@@ rtl/mf1d_sort_cell.sv @@
`timescale 1ns / 1ps
// One cell of the insertion sorting row: holds one value, kept ascending.
// Depends on nothing.
module mf1d_sort_cell #(
    parameter int SW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_ins,
    input  logic signed [SW-1:0] i_v,
    input  logic                 i_left_gt,
    input  logic                 i_left_full,
    input  logic signed [SW-1:0] i_left_val,
    output logic                 o_gt,
    output logic                 o_full,
    output logic signed [SW-1:0] o_val
);
    logic                 r_full;
    logic signed [SW-1:0] r_val;

    assign o_gt   = !r_full || (i_v < r_val);
    assign o_full = r_full;
    assign o_val  = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_full <= 1'b0;
        end else if (i_ins && o_gt) begin
            if (i_left_gt) begin
                if (i_left_full) begin
                    r_val  <= i_left_val;
                    r_full <= 1'b1;
                end
            end else begin
                r_val  <= i_v;
                r_full <= 1'b1;
            end
        end
    end
endmodule

@@ rtl/mf1d_sorter.sv @@
`timescale 1ns / 1ps
// Row of sort cells; one value enters per cycle, the chosen rank is read out.
// Depends on mf1d_sort_cell.
module mf1d_sorter #(
    parameter int DEPTH = 31,
    parameter int SW    = 16,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_ins,
    input  logic signed [SW-1:0] i_v,
    input  logic [AW-1:0]        i_rank,
    output logic signed [SW-1:0] o_val
);
    logic                 w_gt   [DEPTH];
    logic                 w_full [DEPTH];
    logic signed [SW-1:0] w_val  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 l_gt;
        logic                 l_full;
        logic signed [SW-1:0] l_val;
        if (g == 0) begin : g_first
            assign l_gt   = 1'b0;
            assign l_full = 1'b0;
            assign l_val  = '0;
        end else begin : g_rest
            assign l_gt   = w_gt[g-1];
            assign l_full = w_full[g-1];
            assign l_val  = w_val[g-1];
        end
        mf1d_sort_cell #(.SW(SW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (i_clear),
            .i_ins       (i_ins),
            .i_v         (i_v),
            .i_left_gt   (l_gt),
            .i_left_full (l_full),
            .i_left_val  (l_val),
            .o_gt        (w_gt[g]),
            .o_full      (w_full[g]),
            .o_val       (w_val[g])
        );
    end

    assign o_val = w_val[i_rank];
endmodule

@@ rtl/median_filter_1d_padded.sv @@
`timescale 1ns / 1ps
// Padded 1-D median filter, top level.
// Depends on mf1d_pkg and mf1d_sorter.
//
// Input requests carry one sample and a last-in-frame flag (valid/ready).
// Output requests carry a median, its frame position and a frame-done flag.
// Config writes (padding mode, radius) go through i_cfg_we/index/data;
// the user makes them between frames while the block is idle; the block has no check for this.
// Each request is taken while the block is idle; it yields zero, one or,
// on the last sample of a frame, several outputs. Each output takes sorter
// feeding and control, plus index wrapping when its window starts before
// the frame start; the sorter row takes one window value per cycle.
// Output is held in a register until taken; a stalled receiver holds the
// block, and no new sample is taken until all outputs of the last one are
// delivered.
// Reset (synchronous) empties the sorter and control, sets mode to wrap,
// radius to 2 and the sample count to zero.
module median_filter_1d_padded #(
    parameter int MAX_RADIUS   = 15,
    parameter int MAX_FRAME    = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last_in_frame,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_median_value,
    output logic [$clog2(MAX_FRAME)-1:0]   o_position,
    output logic                           o_frame_done,
    input  logic                           i_cfg_we,
    input  logic [mf1d_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [mf1d_pkg::CFG_W-1:0]     i_cfg_data
);
    import mf1d_pkg::*;

    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int HEAD_DEPTH = 2 * MAX_RADIUS;
    localparam int WIN_AW     = $clog2(WIN_DEPTH);
    localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int POS_W      = $clog2(MAX_FRAME);
    localparam int LEN_W      = POS_W + 1;
    localparam int IDX_W      = LEN_W + 1;

    t_state r_state;
    logic [MODE_W-1:0]   r_mode;
    logic [RADIUS_W-1:0] r_radius;
    logic [POS_W-1:0]    r_count;

    logic signed [SAMPLE_WIDTH-1:0] r_win  [WIN_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_head [HEAD_DEPTH];

    logic [POS_W-1:0]        r_n;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        r_p;
    logic [LEN_W-1:0]        r_first_end;
    logic [LEN_W-1:0]        r_start;
    logic                    r_seg;
    logic signed [IDX_W-1:0] r_raw;
    logic signed [IDX_W-1:0] r_w;
    logic [WIN_AW-1:0]       r_i;

    logic                           r_fv;
    logic                           r_fz;
    logic                           r_fw;
    logic                           r_fh;
    logic signed [SAMPLE_WIDTH-1:0] r_fwv;
    logic signed [SAMPLE_WIDTH-1:0] r_hq;

    logic signed [SAMPLE_WIDTH-1:0] r_med;
    logic [POS_W-1:0]               r_pos;
    logic                           r_done;

    logic [RAD_W-1:0]  w_r;
    logic [WIN_AW-1:0] w_two_r;
    logic              w_accept;
    logic              w_out_take;

    assign w_r        = (int'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                      : RAD_W'(r_radius);
    assign w_two_r    = WIN_AW'({w_r, 1'b0});
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign w_out_take  = o_out_valid && i_out_ready;
    assign o_median_value = r_med;
    assign o_position     = r_pos;
    assign o_frame_done   = r_done;

    // plan on accept
    logic [LEN_W-1:0]        n_len;
    logic [LEN_W-1:0]        n_lo;
    logic [LEN_W-1:0]        n_first_end;
    logic signed [IDX_W-1:0] n_start_s;
    logic [LEN_W-1:0]        n_start;
    logic                    n_emit_one;

    always_comb begin
        n_len       = LEN_W'(r_count) + LEN_W'(1);
        n_lo        = (r_mode == MODE_WRAP) ? LEN_W'(w_r) : '0;
        n_first_end = (n_lo < n_len) ? n_lo : n_len;
        n_start_s   = $signed(IDX_W'(n_len)) - $signed(IDX_W'(1))
                      - $signed(IDX_W'(w_r));
        n_start     = (n_start_s < $signed(IDX_W'(n_lo))) ? n_lo
                                                          : n_start_s[LEN_W-1:0];
        n_emit_one  = (r_count >= POS_W'(w_r)) &&
                      ((r_mode != MODE_WRAP) || (r_count >= POS_W'(w_two_r)));
    end

    // index fetch
    logic                    n_neg;
    logic                    n_ge;
    logic                    n_zero;
    logic signed [IDX_W-1:0] n_x;
    logic signed [IDX_W-1:0] n_d;
    logic                    n_usewin;
    logic                    n_headok;
    logic [WIN_AW-1:0]       n_widx;
    logic [HEAD_AW-1:0]      n_haddr;

    always_comb begin
        n_neg  = r_raw < 0;
        n_ge   = (r_len != '0) && (r_raw >= $signed(IDX_W'(r_len)));
        n_zero = 1'b0;
        n_x    = r_raw;
        if (n_neg || n_ge) begin
            case (r_mode)
                MODE_WRAP: begin
                    n_zero = (r_len == '0);
                    n_x    = r_w;
                end
                MODE_EDGE: begin
                    n_x = n_neg ? '0 : $signed(IDX_W'(r_len)) - $signed(IDX_W'(1));
                end
                default: begin
                    n_zero = 1'b1;
                end
            endcase
        end
        if (n_x < 0 || n_x > $signed(IDX_W'(r_n))) begin
            n_zero = 1'b1;
        end
        n_d      = $signed(IDX_W'(r_n)) - n_x;
        n_usewin = (n_d >= 0) && (n_d <= $signed(IDX_W'(w_two_r)));
        n_headok = (n_x >= 0) && (n_x < $signed(IDX_W'(HEAD_DEPTH)));
        n_widx   = n_usewin ? n_d[WIN_AW-1:0] : '0;
        n_haddr  = n_headok ? n_x[HEAD_AW-1:0] : '0;
    end

    logic signed [SAMPLE_WIDTH-1:0] w_feed;
    logic signed [SAMPLE_WIDTH-1:0] w_median;

    assign w_feed = r_fz ? '0 : (r_fw ? r_fwv : (r_fh ? r_hq : '0));

    mf1d_sorter #(.DEPTH(WIN_DEPTH), .SW(SAMPLE_WIDTH), .AW(WIN_AW)) u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (r_state == S_BEGIN),
        .i_ins   (r_fv),
        .i_v     (w_feed),
        .i_rank  (WIN_AW'(w_r)),
        .o_val   (w_median)
    );

    // window shift line and head store
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win[0] <= i_sample;
            for (int k = 1; k < WIN_DEPTH; k++) begin
                r_win[k] <= r_win[k-1];
            end
            if (r_count < POS_W'(HEAD_DEPTH)) begin
                r_head[r_count[HEAD_AW-1:0]] <= i_sample;
            end
        end
        r_hq  <= r_head[n_haddr];
        r_fwv <= r_win[n_widx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_WRAP;
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PADDING_MODE: begin
                    r_mode <= (i_cfg_data[MODE_W-1:0] == MODE_UNUSED) ? MODE_ZERO
                                                                     : i_cfg_data[MODE_W-1:0];
                end
                REG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_fv    <= 1'b0;
        end else begin
            r_fv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n <= r_count;
                        if (!i_last_in_frame) begin
                            r_count <= (int'(r_count) == MAX_FRAME - 1) ? '0
                                                                        : r_count + 1'b1;
                            r_len <= '0;
                            r_p   <= LEN_W'(r_count) - LEN_W'(w_r);
                            if (n_emit_one) begin
                                r_state <= S_BEGIN;
                            end
                        end else begin
                            r_count     <= '0;
                            r_len       <= n_len;
                            r_first_end <= n_first_end;
                            r_start     <= n_start;
                            if (n_first_end != '0) begin
                                r_p     <= '0;
                                r_seg   <= 1'b0;
                                r_state <= S_BEGIN;
                            end else begin
                                r_p     <= n_start;
                                r_seg   <= 1'b1;
                                r_state <= (n_start < n_len) ? S_BEGIN : S_IDLE;
                            end
                        end
                    end
                end
                S_BEGIN: begin
                    r_raw   <= $signed(IDX_W'(r_p)) - $signed(IDX_W'(w_r));
                    r_w     <= $signed(IDX_W'(r_p)) - $signed(IDX_W'(w_r));
                    r_i     <= '0;
                    r_state <= S_WFIX;
                end
                S_WFIX: begin
                    if (r_w < 0 && r_len != '0) begin
                        r_w <= r_w + $signed(IDX_W'(r_len));
                    end else begin
                        r_state <= S_FEED;
                    end
                end
                S_FEED: begin
                    r_fv  <= 1'b1;
                    r_fz  <= n_zero;
                    r_fw  <= n_usewin;
                    r_fh  <= n_headok;
                    r_raw <= r_raw + $signed(IDX_W'(1));
                    r_w   <= (r_w + $signed(IDX_W'(1)) == $signed(IDX_W'(r_len))) ? '0
                             : r_w + $signed(IDX_W'(1));
                    r_i   <= r_i + 1'b1;
                    if (r_i == w_two_r) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_med   <= w_median;
                    r_pos   <= r_p[POS_W-1:0];
                    r_done  <= (r_len != '0) && (r_p == r_len - 1'b1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_take) begin
                        if (r_len == '0) begin
                            r_state <= S_IDLE;
                        end else if (!r_seg && (r_p + 1'b1 < r_first_end)) begin
                            r_p     <= r_p + 1'b1;
                            r_state <= S_BEGIN;
                        end else if (!r_seg) begin
                            r_seg   <= 1'b1;
                            r_p     <= r_start;
                            r_state <= (r_start < r_len) ? S_BEGIN : S_IDLE;
                        end else if (r_p + 1'b1 < r_len) begin
                            r_p     <= r_p + 1'b1;
                            r_state <= S_BEGIN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/median_filter_1d_padded_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the padded 1-D median filter: directed frames,
// then random frames under random settings and random stalls on both sides.
// Depends on mf1d_pkg and median_filter_1d_padded.
module median_filter_1d_padded_tb;
    import mf1d_pkg::*;

    localparam int MAXR       = 15;
    localparam int WIN_N      = 2 * MAXR + 1;
    localparam int HEAD_N     = 2 * MAXR;
    localparam int NUM_ITEMS  = 200;
    localparam int IDLE_LIM   = 4000;
    localparam int SETTLE     = 100;
    localparam int LONG_STALL = 300;

    typedef struct {
        logic signed [15:0] med;
        logic [11:0]        pos;
        logic               done;
    } t_median;

    typedef enum int { PAT_CONST, PAT_ALT, PAT_RAND } t_pattern;

    typedef struct {
        logic               set_cfg;
        logic [MODE_W-1:0]  mode;
        logic [3:0]         rad;
        int                 len;
        logic signed [15:0] val;
        t_pattern           pat;
        logic               typed;
    } t_frame_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic signed [15:0]  sample = '0;
    logic                last_in_frame = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [15:0]  median_value;
    logic [11:0]         position;
    logic                frame_done;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    t_median             pending_medians[$];
    int                  errors = 0;
    int                  idle_cycles = 0;
    int                  hold_off = 0;
    logic                calm = 1'b0;
    logic                stall_go = 1'b0;
    logic                long_stall = 1'b0;
    logic                typed_on = 1'b0;
    logic signed [15:0]  typed_med;

    logic signed [15:0]  hist[WIN_N];
    logic signed [15:0]  head[HEAD_N];
    int                  n_seen = 0;
    logic [MODE_W-1:0]   cur_mode = MODE_WRAP;
    int                  cur_rad = 2;

    median_filter_1d_padded u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_sample(sample), .i_last_in_frame(last_in_frame),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_median_value(median_value), .o_position(position),
        .o_frame_done(frame_done),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [15:0] stored(int idx, int n, int r);
        int d;
        if (idx < 0 || idx > n) return '0;
        d = n - idx;
        if (d <= 2 * r && d < WIN_N) return hist[d];
        if (idx < HEAD_N) return head[idx];
        return '0;
    endfunction

    function automatic logic signed [15:0] edge_fill(int idx, int n, int len, int r);
        logic outside;
        outside = idx < 0 || (len > 0 && idx >= len);
        if (!outside) return stored(idx, n, r);
        if (cur_mode == MODE_WRAP) begin
            if (len <= 0) return '0;
            return stored(((idx % len) + len) % len, n, r);
        end
        if (cur_mode == MODE_EDGE)
            return idx < 0 ? stored(0, n, r) : stored(len - 1, n, r);
        return '0;
    endfunction

    function automatic logic signed [15:0] window_median(int p, int n, int len, int r);
        logic signed [15:0] srt[WIN_N];
        logic signed [15:0] v;
        int j;
        for (int i = 0; i < 2 * r + 1; i++) begin
            v = edge_fill(p - r + i, n, len, r);
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        return srt[r];
    endfunction

    task automatic push_median(int p, int n, int len, int r, logic done);
        t_median m;
        m.med  = typed_on ? typed_med : window_median(p, n, len, r);
        m.pos  = p[11:0];
        m.done = done;
        pending_medians.push_back(m);
    endtask

    task automatic predict_medians(logic signed [15:0] s, logic last);
        int n, len, lo, first_end, start;
        n = n_seen;
        for (int i = WIN_N - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = s;
        if (n < HEAD_N) head[n] = s;
        if (!last) begin
            if (n >= cur_rad && (cur_mode != MODE_WRAP || n >= 2 * cur_rad))
                push_median(n - cur_rad, n, 0, cur_rad, 1'b0);
            n_seen = (n_seen + 1) % 4096;
        end else begin
            len = n + 1;
            lo = cur_mode == MODE_WRAP ? cur_rad : 0;
            first_end = lo < len ? lo : len;
            start = len - 1 - cur_rad;
            if (start < lo) start = lo;
            for (int p = 0; p < first_end; p++)
                push_median(p, n, len, cur_rad, p == len - 1);
            for (int p = start; p < len; p++)
                push_median(p, n, len, cur_rad, p == len - 1);
            n_seen = 0;
        end
    endtask

    function automatic int pick_gap();
        int k;
        if (calm) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 90) return $urandom_range(1, 3);
        if (k < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(logic signed [15:0] s, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample        <= s;
        last_in_frame <= last;
        do @(posedge clk); while (!in_ready);
        predict_medians(s, last);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PADDING_MODE)
            cur_mode = val[1:0] == MODE_UNUSED ? MODE_ZERO : val[1:0];
        else
            cur_rad = val > MAXR ? MAXR : int'(val);
    endtask

    task automatic set_filter(logic [MODE_W-1:0] mode, logic [3:0] rad);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_medians.size() == 0);
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_PADDING_MODE, CFG_W'(mode));
        write_reg(REG_RADIUS, rad);
    endtask

    task automatic send_frame(int len, t_pattern pat, logic signed [15:0] val);
        logic signed [15:0] s;
        for (int i = 0; i < len; i++) begin
            case (pat)
                PAT_CONST: s = val;
                PAT_ALT:   s = i[0] ? 16'sh8000 : 16'sh7fff;
                default:   s = pick_sample();
            endcase
            send_request(s, i == len - 1);
        end
    endtask

    t_frame_row directed[7] = '{
        '{1'b0, MODE_WRAP, 4'd2, 5, 16'sh7fff, PAT_CONST, 1'b1},
        '{1'b1, MODE_EDGE, 4'd1, 3, 16'sh8000, PAT_CONST, 1'b1},
        '{1'b1, MODE_ZERO, 4'd1, 3, 16'sh0000, PAT_ALT, 1'b0},
        '{1'b1, MODE_UNUSED, 4'd0, 2, 16'sh0000, PAT_ALT, 1'b0},
        '{1'b1, MODE_WRAP, 4'd2, 3, 16'sh0000, PAT_RAND, 1'b0},
        '{1'b1, MODE_WRAP, 4'd1, 1, 16'sh1234, PAT_RAND, 1'b0},
        '{1'b1, MODE_EDGE, 4'd15, 4, 16'sh0000, PAT_RAND, 1'b0}
    };

    // long receiver hold-off, counted here
    initial begin
        wait (stall_go);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        long_stall <= 1'b0;
    end

    always @(posedge clk) begin
        t_median m;
        if (out_valid && out_ready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: unexpected result pos %0d med %0d", $time,
                         position, median_value);
                errors++;
            end else begin
                m = pending_medians.pop_front();
                if (median_value !== m.med || position !== m.pos
                        || frame_done !== m.done) begin
                    $display("%0t: expected med %0d pos %0d done %0b, got %0d %0d %0b",
                             $time, m.med, m.pos, m.done, median_value, position,
                             frame_done);
                    errors++;
                end
            end
        end
        if (!rst_n) out_ready <= 1'b0;
        else if (long_stall) out_ready <= 1'b0;
        else if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end else if (calm) out_ready <= 1'b1;
        else begin
            case ($urandom_range(0, 49))
                0:       hold_off <= $urandom_range(20, 50);
                1, 2, 3: hold_off <= $urandom_range(1, 5);
                default: ;
            endcase
            out_ready <= $urandom_range(0, 3) != 0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIM) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int sent, r, len, frames;
        logic [MODE_W-1:0] mode;
        for (int i = 0; i < WIN_N; i++) hist[i] = '0;
        for (int i = 0; i < HEAD_N; i++) head[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            if (directed[i].set_cfg) set_filter(directed[i].mode, directed[i].rad);
            typed_on  = directed[i].typed;
            typed_med = directed[i].val;
            send_frame(directed[i].len, directed[i].pat, directed[i].val);
            typed_on = 1'b0;
        end

        sent = 0;
        while (sent < NUM_ITEMS) begin
            mode = MODE_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: r = 0;
                1: r = 15;
                default: r = $urandom_range(1, 4);
            endcase
            set_filter(mode, r[3:0]);
            calm = $urandom_range(0, 4) == 0;
            if (!stall_go && sent >= NUM_ITEMS / 2) stall_go = 1'b1;
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 2 * r + 1);
                else len = 2 * r + 1 + $urandom_range(0, 12);
                send_frame(len, PAT_RAND, '0);
                sent += len;
            end
            calm = 1'b0;
        end
        in_valid <= 1'b0;
        wait (pending_medians.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending_medians.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
